// ===== design/spq_pkg.sv =====
package spq_pkg;

    // Queue depth and the key and count widths.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OCC_W    = 5;

    // Operation codes of a command word.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    // Status codes of a response word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic                    insert;
        logic                    remove;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    place;
    } t_link;

endpackage

// ===== design/spq_if.sv =====
// Command channel: one operation per word.
interface spq_in_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_opcode                 opcode;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

// Response channel: one word per command.
interface spq_out_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] removed_value;
    t_status                 status;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    output ready);
endinterface

// ===== design/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_occupied,
    input  t_link                   i_left,
    input  logic signed [KEY_W-1:0] i_right_key,
    output t_link                   o_link
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_place;

    // The new key belongs at or before this cell if the cell is free or holds a larger key.
    // Equal keys stay ahead, so ties leave in arrival order.
    assign w_place = !i_occupied || (r_key > i_ctl.key);

    // Insert shifts right from the insertion point; remove shifts everything left.
    always_comb begin
        n_key = r_key;
        if (i_ctl.insert && w_place) begin
            n_key = i_left.place ? i_left.key : i_ctl.key;
        end else if (i_ctl.remove) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link.key   = r_key;
    assign o_link.place = w_place;

endmodule

// ===== design/sorted_priority_queue.sv =====
// Sorted min-priority queue built from a row of CAPACITY cells.
// i_cmd carries command words: opcode OP_INSERT stores key, OP_REMOVE takes out
// the smallest stored key. Equal keys leave in the order they arrived.
// o_rsp carries one response word per command: the removed key (0 otherwise),
// a status (ok, remove while empty, insert while full) and the number of
// entries stored after the command.
// Every cell compares its key with the broadcast key and shifts in parallel, so
// a command is taken every cycle while the output register is free or being
// emptied, and its response is registered in the output register on acceptance.
// The output register is the only buffer: while the receiver stalls with a
// response pending, i_cmd.ready stays low; a command is accepted in the same
// cycle the pending response is taken.
// An insert into a full queue is dropped, a remove from an empty queue leaves
// the queue unchanged. Reset empties the queue and clears the output valid;
// the cell contents are not reset.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_cmd,
    spq_out_if.source   o_rsp
);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_value;
    logic signed [KEY_W-1:0] n_value;
    t_status                 r_status;
    t_status                 n_status;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    t_cell_ctl               w_ctl;
    t_link                   w_link [CAPACITY];

    // Handshake: a command enters when the output register is free or being emptied.
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // Broadcast control to the cells.
    assign w_ctl.insert = w_accept && (i_cmd.opcode == OP_INSERT) && !w_full;
    assign w_ctl.remove = w_accept && (i_cmd.opcode == OP_REMOVE) && !w_empty;
    assign w_ctl.key    = i_cmd.key;

    // Row of cells; while the queue holds entries, the front cell holds the smallest key.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link                   w_left;
        logic signed [KEY_W-1:0] w_right_key;
        logic                    w_occupied;

        assign w_occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_front
            assign w_left.key   = '0;
            assign w_left.place = 1'b0;
        end else begin : g_inner
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_right_key = w_link[g].key;
        end else begin : g_mid
            assign w_right_key = w_link[g+1].key;
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (w_occupied),
            .i_left      (w_left),
            .i_right_key (w_right_key),
            .o_link      (w_link[g])
        );
    end

    // Next count and response word.
    always_comb begin
        n_count  = r_count;
        n_value  = '0;
        n_status = ST_OK;
        if (i_cmd.opcode == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_value = w_link[0].key;
                n_count = r_count - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_value;
    assign o_rsp.status        = r_status;
    assign o_rsp.occupancy     = OCC_W'(r_count);

endmodule
